>>> hw/rtl/assert_macros.svh
// Concurrent assertion helpers, clocked on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check while out of reset.
`define TMF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check at every edge, reset included.
`define TMF_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/tmf_pkg.sv
package tmf_pkg;

	localparam int MAX_SAMPLES = 16;
	localparam int SAMPLE_BITS = 10;

	localparam int ADDR_W   = $clog2(MAX_SAMPLES);
	localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
	localparam int TRIM_W   = 4;
	localparam int TW       = (CNT_W > TRIM_W) ? CNT_W : TRIM_W;
	localparam int SUM_W    = SAMPLE_BITS + CNT_W;
	localparam int DCNT_W   = $clog2(SUM_W);
	localparam int MEAN_W   = 10;
	localparam int KEPT_W   = 5;
	localparam int STATUS_W = 2;

	localparam logic [TRIM_W-1:0] TRIM_RESET = TRIM_W'(2);

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

endpackage

>>> hw/rtl/tmf_if.sv
interface tmf_sample_if;
	import tmf_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;
	logic                   last;
	modport source (output valid, sample, last, input ready);
	modport sink (input valid, sample, last, output ready);
endinterface

interface tmf_result_if;
	import tmf_pkg::*;
	logic                valid;
	logic                ready;
	logic [MEAN_W-1:0]   mean;
	logic [KEPT_W-1:0]   kept_count;
	logic [STATUS_W-1:0] status;
	modport source (output valid, mean, kept_count, status, input ready);
	modport sink (input valid, mean, kept_count, status, output ready);
endinterface

interface tmf_cfg_if;
	import tmf_pkg::*;
	logic              valid;
	logic              ready;
	logic [TRIM_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> hw/rtl/tmf_ram.sv
module tmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hw/rtl/trimmed_mean_filter.sv
// Trimmed mean over a frame of samples.
// samples: one sample per transfer, last set on the final sample of a frame.
//   Up to MAX_SAMPLES are stored; further samples are dropped and flagged.
// results: one transfer per frame with mean, kept_count and status
//   (ok, nothing left after trim, overflow).
// cfg: writes trim_count; always ready, write only while idle.
// Samples of a frame are taken one per cycle while loading. After the last
// one, a shared compare unit ranks each stored sample against all others
// through the single read port of the sample RAM; then, if any sample is
// kept, a shift-subtract divider forms the mean before the result is posted.
// samples.ready is low from the last sample until the result is posted.
// The result sits in an output register; a stall there holds it and lets the
// next frame load, and only the next frame's result waits for it to drain.
// Reset empties the frame, drops any pending result and sets trim_count to 2.
module trimmed_mean_filter (
	input logic         clk,
	input logic         arst_n,
	tmf_sample_if.sink   samples,
	tmf_result_if.source results,
	tmf_cfg_if.sink      cfg
);
	import tmf_pkg::*;

	localparam logic [2:0] S_LOAD  = 3'd0;
	localparam logic [2:0] S_OUTER = 3'd1;
	localparam logic [2:0] S_CAPT  = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_ACC   = 3'd4;
	localparam logic [2:0] S_PREP  = 3'd5;
	localparam logic [2:0] S_DIV   = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]             state_q;
	logic [TRIM_W-1:0]      trim_q;
	logic [CNT_W-1:0]       fill_q;
	logic                   ovf_q;
	logic [ADDR_W-1:0]      i_q;
	logic [CNT_W-1:0]       j_q;
	logic [ADDR_W-1:0]      jd_q;
	logic [CNT_W-1:0]       rank_q;
	logic [SAMPLE_BITS-1:0] vi_q;
	logic [SUM_W-1:0]       sum_q;
	logic [SUM_W-1:0]       quo_q;
	logic [CNT_W-1:0]       rem_q;
	logic [DCNT_W-1:0]      d_q;
	logic                   res_valid_q;
	logic [MEAN_W-1:0]      res_mean_q;
	logic [KEPT_W-1:0]      res_kept_q;
	logic [STATUS_W-1:0]    res_status_q;

	logic                   in_fire;
	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_raddr;
	logic [SAMPLE_BITS-1:0] ram_rdata;
	logic [TW-1:0]          n_w, trim_w, r_w, hi_w, lo_w, kept_w;
	logic [CNT_W-1:0]       div_w;
	logic                   less_w;
	logic [CNT_W:0]         rem_sh_w, rem_nx_w;
	logic                   ge_w;
	logic                   in_range_w;
	logic                   post_w;

	assign samples.ready = (state_q == S_LOAD);
	assign in_fire       = samples.valid && samples.ready;
	assign ram_we        = in_fire && (fill_q < CNT_W'(MAX_SAMPLES));
	assign ram_raddr     = (state_q == S_OUTER) ? i_q : j_q[ADDR_W-1:0];
	assign post_w        = (state_q == S_DONE) && (!res_valid_q || results.ready);

	assign cfg.ready = 1'b1;

	assign results.valid      = res_valid_q;
	assign results.mean       = res_mean_q;
	assign results.kept_count = res_kept_q;
	assign results.status     = res_status_q;

	tmf_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(MAX_SAMPLES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(fill_q[ADDR_W-1:0]),
		.wdata(samples.sample),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// trim the largest first, then the smallest of what is left
	always_comb begin
		n_w    = TW'(fill_q);
		trim_w = TW'(trim_q);
		r_w    = (trim_w < n_w) ? trim_w : n_w;
		hi_w   = n_w - r_w;
		lo_w   = (trim_w < hi_w) ? trim_w : hi_w;
		kept_w = hi_w - lo_w;
		div_w  = CNT_W'(kept_w);
	end

	assign less_w = (ram_rdata < vi_q) || ((ram_rdata == vi_q) && (jd_q < i_q));
	assign in_range_w = (TW'(rank_q) >= lo_w) && (TW'(rank_q) < hi_w);

	assign rem_sh_w = {rem_q, quo_q[SUM_W-1]};
	assign ge_w     = rem_sh_w >= {1'b0, div_w};
	assign rem_nx_w = ge_w ? (rem_sh_w - {1'b0, div_w}) : rem_sh_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trim_q <= TRIM_RESET;
		end else if (cfg.valid && cfg.ready) begin
			trim_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (post_w) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			fill_q      <= '0;
			ovf_q       <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_fire) begin
						if (ram_we) begin
							fill_q <= fill_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (samples.last) begin
							state_q <= S_OUTER;
						end
					end
				end
				S_OUTER: state_q <= S_CAPT;
				S_CAPT:  state_q <= S_SCAN;
				S_SCAN: begin
					if (CNT_W'(jd_q) == fill_q - CNT_W'(1)) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (CNT_W'(i_q) == fill_q - CNT_W'(1)) begin
						state_q <= S_PREP;
					end else begin
						state_q <= S_OUTER;
					end
				end
				S_PREP: state_q <= (kept_w == '0) ? S_DONE : S_DIV;
				S_DIV: begin
					if (d_q == '0) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (post_w) begin
						fill_q      <= '0;
						ovf_q       <= 1'b0;
						state_q     <= S_LOAD;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_LOAD: begin
				i_q   <= '0;
				sum_q <= '0;
			end
			S_OUTER: j_q <= '0;
			S_CAPT: begin
				vi_q   <= ram_rdata;
				rank_q <= '0;
				jd_q   <= '0;
				j_q    <= j_q + CNT_W'(1);
			end
			S_SCAN: begin
				rank_q <= rank_q + CNT_W'(less_w);
				jd_q   <= jd_q + ADDR_W'(1);
				j_q    <= j_q + CNT_W'(1);
			end
			S_ACC: begin
				if (in_range_w) begin
					sum_q <= sum_q + SUM_W'(vi_q);
				end
				i_q <= i_q + ADDR_W'(1);
			end
			S_PREP: begin
				quo_q <= (kept_w == '0) ? '0 : sum_q;
				rem_q <= '0;
				d_q   <= DCNT_W'(SUM_W - 1);
			end
			S_DIV: begin
				rem_q <= rem_nx_w[CNT_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], ge_w};
				d_q   <= d_q - DCNT_W'(1);
			end
			S_DONE: begin
				if (post_w) begin
					res_mean_q <= MEAN_W'(quo_q);
					res_kept_q <= KEPT_W'(kept_w);
					if (kept_w == '0) begin
						res_status_q <= STATUS_EMPTY;
					end else if (ovf_q) begin
						res_status_q <= STATUS_OVERFLOW;
					end else begin
						res_status_q <= STATUS_OK;
					end
				end
			end
		endcase
	end

`include "assert_macros.svh"

	`TMF_ASSERT(a_last_blocks, in_fire && samples.last |=> !samples.ready, "ready after last")
	`TMF_ASSERT(a_empty_zero, res_valid_q && (res_status_q == STATUS_EMPTY) |-> (res_mean_q == '0) && (res_kept_q == '0), "empty result not zero")
	`TMF_ASSERT(a_kept_bound, res_valid_q |-> (res_kept_q <= KEPT_W'(MAX_SAMPLES)), "kept count too large")
	`TMF_ASSERT(a_fill_bound, fill_q <= CNT_W'(MAX_SAMPLES), "fill count past store")

endmodule

>>> tb/trimmed_mean_filter_tb.sv
module trimmed_mean_filter_tb;
	import tmf_pkg::*;

	localparam int CLK_PERIOD  = 8;
	localparam int RESET_CYCLES = 5;
	localparam int ITEM_TARGET = 900;
	localparam int PHASE_ITEMS = 90;
	localparam int SETTLE_CYCLES = 40;
	localparam int LONG_HOLD_CYCLES = 400;

	typedef struct packed {
		logic [MEAN_W-1:0]   mean;
		logic [KEPT_W-1:0]   kept_count;
		logic [STATUS_W-1:0] status;
	} frame_result_t;

	class trim_mean_scoreboard;
		logic [SAMPLE_BITS-1:0] frame_store[MAX_SAMPLES];
		int unsigned            stored;
		bit                     dropped;
		logic [TRIM_W-1:0]      trim;
		frame_result_t          expected_q[$];
		int unsigned            failures;

		function new();
			stored = 0;
			dropped = 0;
			trim = TRIM_RESET;
			failures = 0;
		endfunction

		function void set_trim(logic [TRIM_W-1:0] value);
			trim = value;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function void note_sample(logic [SAMPLE_BITS-1:0] value, logic is_last);
			int unsigned   sorted[MAX_SAMPLES];
			int unsigned   n, r, hi, lo, kept, sum, x;
			int            i, j;
			frame_result_t res;
			if (stored < MAX_SAMPLES) begin
				frame_store[stored] = value;
				stored++;
			end else begin
				dropped = 1;
			end
			if (!is_last)
				return;
			n = stored;
			for (i = 0; i < int'(n); i++)
				sorted[i] = frame_store[i];
			for (i = 1; i < int'(n); i++) begin
				x = sorted[i];
				j = i;
				while (j > 0 && sorted[j-1] > x) begin
					sorted[j] = sorted[j-1];
					j--;
				end
				sorted[j] = x;
			end
			r = (trim < n) ? trim : n;
			hi = n - r;
			lo = (trim < hi) ? trim : hi;
			kept = hi - lo;
			sum = 0;
			for (i = int'(lo); i < int'(hi); i++)
				sum += sorted[i];
			if (kept == 0) begin
				res.mean = '0;
				res.status = STATUS_EMPTY;
			end else begin
				res.mean = MEAN_W'(sum / kept);
				res.status = dropped ? STATUS_OVERFLOW : STATUS_OK;
			end
			res.kept_count = KEPT_W'(kept);
			expected_q.push_back(res);
			stored = 0;
			dropped = 0;
		endfunction

		function void check_result(logic [MEAN_W-1:0] mean, logic [KEPT_W-1:0] kept_count,
				logic [STATUS_W-1:0] status);
			frame_result_t want;
			if (expected_q.size() == 0) begin
				$error("result transfer with no frame pending: mean %0d kept_count %0d status %0d",
					mean, kept_count, status);
				failures++;
				return;
			end
			want = expected_q.pop_front();
			if (mean !== want.mean) begin
				$error("mean: expected %0d, actual %0d", want.mean, mean);
				failures++;
			end
			if (kept_count !== want.kept_count) begin
				$error("kept_count: expected %0d, actual %0d", want.kept_count, kept_count);
				failures++;
			end
			if (status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, status);
				failures++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	tmf_sample_if samples_if();
	tmf_result_if results_if();
	tmf_cfg_if    cfg_if();

	trimmed_mean_filter i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if),
		.cfg     (cfg_if)
	);

	trim_mean_scoreboard sb = new();

	bit          tx_steady;
	bit          rx_steady;
	bit          long_hold_req;
	int unsigned sent_items;

	initial begin
		clk = 0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(CLK_PERIOD * 1000000);
		$display("Test completed with failures");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && samples_if.valid && samples_if.ready)
			sb.note_sample(samples_if.sample, samples_if.last);
		if (arst_n && results_if.valid && results_if.ready)
			sb.check_result(results_if.mean, results_if.kept_count, results_if.status);
	end

	function automatic int unsigned idle_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 20)
			return '1;
		return SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
	endfunction

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int unsigned stall_left;
		results_if.ready = 0;
		stall_left = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (stall_left > 0) begin
				results_if.ready <= 0;
				stall_left--;
			end else if (long_hold_req) begin
				long_hold_req = 0;
				results_if.ready <= 0;
				stall_left = LONG_HOLD_CYCLES - 1;
			end else begin
				results_if.ready <= 1;
				if (!rx_steady && $urandom_range(0, 99) < 30)
					stall_left = idle_gap() + 1;
			end
			@(posedge clk);
		end
	end

	task automatic send_sample(logic [SAMPLE_BITS-1:0] value, logic is_last);
		int unsigned gap;
		gap = tx_steady ? 0 : idle_gap();
		if (gap > 0) begin
			samples_if.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		samples_if.valid  <= 1;
		samples_if.sample <= value;
		samples_if.last   <= is_last;
		@(posedge clk);
		while (!samples_if.ready) @(posedge clk);
		sent_items++;
	endtask

	task automatic send_frame(int unsigned len, int unsigned mode);
		logic [SAMPLE_BITS-1:0] fixed;
		fixed = pick_sample();
		for (int unsigned i = 0; i < len; i++)
			send_sample((mode == 0) ? fixed : pick_sample(), i == len - 1);
	endtask

	task automatic wait_idle();
		samples_if.valid <= 0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_trim(logic [TRIM_W-1:0] value);
		cfg_if.valid <= 1;
		cfg_if.data  <= value;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		cfg_if.valid <= 0;
		sb.set_trim(value);
	endtask

	initial begin
		int unsigned            phase;
		int unsigned            phase_start;
		int unsigned            len;
		int unsigned            r;
		logic [TRIM_W-1:0]      trim_value;
		arst_n = 0;
		samples_if.valid = 0;
		samples_if.sample = '0;
		samples_if.last = 0;
		cfg_if.valid = 0;
		cfg_if.data = '0;
		tx_steady = 0;
		rx_steady = 0;
		long_hold_req = 0;
		sent_items = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// reset trim: trim as large as a two-sample frame, then equal extremes
		send_sample('0, 0);
		send_sample('1, 1);
		send_sample('1, 0);
		send_sample('0, 0);
		send_sample('1, 0);
		send_sample('0, 0);
		send_sample(SAMPLE_BITS'(512), 0);
		send_sample(SAMPLE_BITS'(777), 1);
		wait_idle();

		// no trim: single sample, then a full store with the last sample dropped
		write_trim('0);
		send_sample('1, 1);
		for (int i = 0; i < MAX_SAMPLES + 1; i++)
			send_sample('1, i == MAX_SAMPLES);
		wait_idle();

		phase = 0;
		while (sent_items < ITEM_TARGET) begin
			case (phase)
				0: trim_value = TRIM_W'(8);
				1: trim_value = '0;
				default: trim_value = TRIM_W'($urandom_range(0, 8));
			endcase
			write_trim(trim_value);
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			if (phase == 3) begin
				tx_steady = 1;
				long_hold_req = 1;
			end
			phase_start = sent_items;
			while (sent_items - phase_start < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (phase == 3)
					len = $urandom_range(1, 4);
				else if (r < 70)
					len = $urandom_range(1, 8);
				else if (r < 90)
					len = $urandom_range(9, MAX_SAMPLES);
				else
					len = $urandom_range(MAX_SAMPLES + 1, MAX_SAMPLES + 4);
				send_frame(len, ($urandom_range(0, 9) == 0) ? 0 : 1);
			end
			wait_idle();
			phase++;
		end

		if (sb.failures == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/tmf_pkg.sv
hw/rtl/tmf_if.sv
hw/rtl/tmf_ram.sv
hw/rtl/trimmed_mean_filter.sv
tb/trimmed_mean_filter_tb.sv
